FILE: hw/rtl/lab_centroid_cell_histogram_core_macros.svh
// Assertion helpers for the checker file of this block.
`ifndef LAB_CENTROID_CELL_HISTOGRAM_CORE_MACROS_SVH
`define LAB_CENTROID_CELL_HISTOGRAM_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCCH_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lab centroid cell histogram core: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LCCH_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lab centroid cell histogram core: assertion failed");

`endif

FILE: hw/rtl/lcch_pkg.sv
`timescale 1ns / 1ps

package lcch_pkg;

  localparam int DEF_MAX_CENTROIDS      = 16;
  localparam int DEF_MAX_CELL_SIZE      = 8;
  localparam int DEF_CENTROID_FRAC_BITS = 8;

  localparam int CELL_REG_W = 4;
  localparam int CEN_REG_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam int SLOT_W     = 4;
  localparam int COMP_W     = 16;
  localparam int PIX_W      = 8;
  localparam int BIN_IDX_W  = 4;
  localparam int BIN_CNT_W  = 7;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 16;

  localparam logic [CELL_REG_W-1:0] CELL_SIZE_RESET = CELL_REG_W'(4);
  localparam logic [CEN_REG_W-1:0]  CENTROIDS_RESET = CEN_REG_W'(16);

  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CENTROIDS = CFG_IDX_W'(1);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  typedef struct packed {
    logic tbl_write;
    logic pix_capture;
    logic scan_issue;
    logic hist_inc;
    logic emit_load;
    logic hist_clear;
  } lcch_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic best_valid;
    logic cell_end;
    logic emit_last;
    logic out_free;
  } lcch_status_t;

endpackage

FILE: hw/rtl/lcch_ctrl.sv
`timescale 1ns / 1ps

module lcch_ctrl import lcch_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         in_op,
  input  lcch_status_t status,
  output logic         in_ready,
  output lcch_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_PIXEL) begin
            cmd.pix_capture = 1'b1;
            state_next      = ST_SCAN;
          end else begin
            cmd.tbl_write = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (status.scan_last) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (status.best_valid) begin
          cmd.hist_inc = 1'b1;
          state_next   = status.cell_end ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit_load = 1'b1;
          if (status.emit_last) begin
            cmd.hist_clear = 1'b1;
            state_next     = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

endmodule

FILE: hw/rtl/lcch_datapath.sv
`timescale 1ns / 1ps

module lcch_datapath import lcch_pkg::*; #(
  parameter int MAX_CENTROIDS      = DEF_MAX_CENTROIDS,
  parameter int MAX_CELL_SIZE      = DEF_MAX_CELL_SIZE,
  parameter int CENTROID_FRAC_BITS = DEF_CENTROID_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lcch_cmd_t             cmd,
  input  logic [CELL_REG_W-1:0] cfg_side,
  input  logic [CEN_REG_W-1:0]  cfg_centroids,
  input  logic [SLOT_W-1:0]     in_slot,
  input  logic [COMP_W-1:0]     in_cen_l,
  input  logic [COMP_W-1:0]     in_cen_a,
  input  logic [COMP_W-1:0]     in_cen_b,
  input  logic [PIX_W-1:0]      in_pix_l,
  input  logic [PIX_W-1:0]      in_pix_a,
  input  logic [PIX_W-1:0]      in_pix_b,
  input  logic                  out_ready,
  output lcch_status_t          status,
  output logic                  out_valid,
  output logic [BIN_IDX_W-1:0]  out_index,
  output logic [BIN_CNT_W-1:0]  out_count,
  output logic                  out_last
);

  localparam int IDX_W  = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
  localparam int NW     = ($clog2(MAX_CENTROIDS + 1) > CEN_REG_W) ?
                          $clog2(MAX_CENTROIDS + 1) : CEN_REG_W;
  localparam int SW     = ($clog2(MAX_CELL_SIZE + 1) > CELL_REG_W) ?
                          $clog2(MAX_CELL_SIZE + 1) : CELL_REG_W;
  localparam int PW     = 2 * SW;
  localparam int CNT_W  = $clog2(MAX_CELL_SIZE * MAX_CELL_SIZE + 1);
  localparam int SH_W   = PIX_W + CENTROID_FRAC_BITS;
  localparam int DIFF_W = (SH_W > COMP_W) ? SH_W : COMP_W;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int DIST_W = SQ_W + 2;

  function automatic logic [DIFF_W-1:0] abs_diff(input logic [PIX_W-1:0] pix,
                                                 input logic [COMP_W-1:0] cen);
    logic [DIFF_W-1:0] p;
    logic [DIFF_W-1:0] c;
    p = DIFF_W'(pix) << CENTROID_FRAC_BITS;
    c = DIFF_W'(cen);
    abs_diff = (p >= c) ? (p - c) : (c - p);
  endfunction

  // Effective register values after clamping to the legal range.
  logic [NW-1:0]    n_ext;
  logic [IDX_W-1:0] last_idx;
  logic [SW-1:0]    side_ext;
  logic [SW-1:0]    side_eff;
  logic [PW-1:0]    per_cell;

  always_comb begin
    n_ext = NW'(cfg_centroids);
    if (n_ext == '0) begin
      last_idx = '0;
    end else if (n_ext > NW'(MAX_CENTROIDS)) begin
      last_idx = IDX_W'(MAX_CENTROIDS - 1);
    end else begin
      last_idx = IDX_W'(n_ext - NW'(1));
    end
    side_ext = SW'(cfg_side);
    if (side_ext == '0) begin
      side_eff = SW'(1);
    end else if (side_ext > SW'(MAX_CELL_SIZE)) begin
      side_eff = SW'(MAX_CELL_SIZE);
    end else begin
      side_eff = side_ext;
    end
    per_cell = PW'(side_eff) * PW'(side_eff);
  end

  logic [3*COMP_W-1:0] tbl [MAX_CENTROIDS];
  logic [3*COMP_W-1:0] rd_data;
  logic [PIX_W-1:0]    pix_l;
  logic [PIX_W-1:0]    pix_a;
  logic [PIX_W-1:0]    pix_b;
  logic [IDX_W-1:0]    k;

  always_ff @(posedge clk) begin
    if (cmd.tbl_write && (32'(in_slot) < 32'(MAX_CENTROIDS))) begin
      tbl[IDX_W'(in_slot)] <= {in_cen_b, in_cen_a, in_cen_l};
    end
    if (cmd.scan_issue) begin
      rd_data <= tbl[k];
    end
    if (cmd.pix_capture) begin
      pix_l <= in_pix_l;
      pix_a <= in_pix_a;
      pix_b <= in_pix_b;
    end
  end

  // Stage one is the table read, stage two the squares, stage three the compare.
  logic             v1;
  logic             first1;
  logic             last1;
  logic [IDX_W-1:0] idx1;
  logic             v2;
  logic             first2;
  logic             last2;
  logic [IDX_W-1:0] idx2;
  logic [SQ_W-1:0]  sq_l;
  logic [SQ_W-1:0]  sq_a;
  logic [SQ_W-1:0]  sq_b;
  logic [DIFF_W-1:0] d_l;
  logic [DIFF_W-1:0] d_a;
  logic [DIFF_W-1:0] d_b;
  logic [DIST_W-1:0] dist_sum;
  logic [DIST_W-1:0] best_dist;
  logic [IDX_W-1:0]  best_idx;
  logic              best_valid;

  assign d_l      = abs_diff(pix_l, rd_data[COMP_W-1:0]);
  assign d_a      = abs_diff(pix_a, rd_data[2*COMP_W-1:COMP_W]);
  assign d_b      = abs_diff(pix_b, rd_data[3*COMP_W-1:2*COMP_W]);
  assign dist_sum = DIST_W'(sq_l) + DIST_W'(sq_a) + DIST_W'(sq_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      k          <= '0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      best_valid <= 1'b0;
    end else begin
      if (cmd.pix_capture) begin
        k <= '0;
      end else if (cmd.scan_issue) begin
        k <= k + IDX_W'(1);
      end
      v1 <= cmd.scan_issue;
      v2 <= v1;
      if (cmd.pix_capture) begin
        best_valid <= 1'b0;
      end else if (v2 && last2) begin
        best_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    first1 <= (k == '0);
    last1  <= (k == last_idx);
    idx1   <= k;
    first2 <= first1;
    last2  <= last1;
    idx2   <= idx1;
    sq_l   <= SQ_W'(d_l) * SQ_W'(d_l);
    sq_a   <= SQ_W'(d_a) * SQ_W'(d_a);
    sq_b   <= SQ_W'(d_b) * SQ_W'(d_b);
    if (v2 && (first2 || (dist_sum < best_dist))) begin
      best_dist <= dist_sum;
      best_idx  <= idx2;
    end
  end

  logic [CNT_W-1:0] hist [MAX_CENTROIDS];
  logic [IDX_W-1:0] hist_addr;
  logic [CNT_W-1:0] hist_rd;
  logic [CNT_W-1:0] pcount;
  logic [IDX_W-1:0] eidx;
  logic             cell_end;

  assign hist_addr = cmd.hist_inc ? best_idx : eidx;
  assign hist_rd   = hist[hist_addr];
  assign cell_end  = (PW'(pcount) + PW'(1)) >= per_cell;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CENTROIDS; i++) begin
        hist[i] <= '0;
      end
      pcount    <= '0;
      eidx      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.hist_clear) begin
        for (int i = 0; i < MAX_CENTROIDS; i++) begin
          hist[i] <= '0;
        end
      end else if (cmd.hist_inc) begin
        hist[best_idx] <= hist_rd + CNT_W'(1);
      end
      if (cmd.hist_inc) begin
        pcount <= cell_end ? '0 : pcount + CNT_W'(1);
        eidx   <= '0;
      end else if (cmd.emit_load) begin
        eidx <= eidx + IDX_W'(1);
      end
      if (cmd.emit_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_index <= BIN_IDX_W'(eidx);
      out_count <= BIN_CNT_W'(hist_rd);
      out_last  <= (eidx == last_idx);
    end
  end

  assign status.scan_last  = (k == last_idx);
  assign status.best_valid = best_valid;
  assign status.cell_end   = cell_end;
  assign status.emit_last  = (eidx == last_idx);
  assign status.out_free   = !out_valid || out_ready;

endmodule

FILE: hw/rtl/lab_centroid_cell_histogram_core.sv
`timescale 1ns / 1ps

// Nearest-centroid Lab color histogram over square cells. Load words (tuser 0)
// write one centroid slot each and leave the block ready for the next word. Pixel
// words (tuser 1) are matched against centroids_in_use table entries, one squared
// distance per cycle through the single table read port, so a pixel occupies the
// block until its read, square and compare stages are through. When a cell of the
// cell side squared pixels is complete, one word per centroid in use leaves on the
// master side at up to one per cycle, tlast on the last, and the counts are cleared;
// no input words are taken during that emission. The final count word may still
// wait on the output while the next input word is accepted. Counts are raw; divide
// by the cell side squared for a fraction. No clearing pass follows reset.

module lab_centroid_cell_histogram_core import lcch_pkg::*; #(
  parameter int MAX_CENTROIDS      = DEF_MAX_CENTROIDS,
  parameter int MAX_CELL_SIZE      = DEF_MAX_CELL_SIZE,
  parameter int CENTROID_FRAC_BITS = DEF_CENTROID_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // centroid_index, centroid_light, centroid_green_red, centroid_blue_yellow,
  // pixel_light, pixel_green_red, pixel_blue_yellow, zero fill
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // operation
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // bin_index, bin_count, zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [CELL_REG_W-1:0] cell_side;
  logic [CEN_REG_W-1:0]  centroids_in_use;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_side        <= CELL_SIZE_RESET;
      centroids_in_use <= CENTROIDS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CELL_SIZE: begin
          cell_side <= cfg_data[CELL_REG_W-1:0];
        end
        REG_CENTROIDS: begin
          centroids_in_use <= cfg_data[CEN_REG_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  lcch_cmd_t             cmd;
  lcch_status_t          status;
  logic [BIN_IDX_W-1:0]  out_index;
  logic [BIN_CNT_W-1:0]  out_count;

  lcch_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser),
    .status   (status),
    .in_ready (s_axis_tready),
    .cmd      (cmd)
  );

  lcch_datapath #(
    .MAX_CENTROIDS      (MAX_CENTROIDS),
    .MAX_CELL_SIZE      (MAX_CELL_SIZE),
    .CENTROID_FRAC_BITS (CENTROID_FRAC_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg_side      (cell_side),
    .cfg_centroids (centroids_in_use),
    .in_slot       (s_axis_tdata[3:0]),
    .in_cen_l      (s_axis_tdata[19:4]),
    .in_cen_a      (s_axis_tdata[35:20]),
    .in_cen_b      (s_axis_tdata[51:36]),
    .in_pix_l      (s_axis_tdata[59:52]),
    .in_pix_a      (s_axis_tdata[67:60]),
    .in_pix_b      (s_axis_tdata[75:68]),
    .out_ready     (m_axis_tready),
    .status        (status),
    .out_valid     (m_axis_tvalid),
    .out_index     (out_index),
    .out_count     (out_count),
    .out_last      (m_axis_tlast)
  );

  assign m_axis_tdata = {(OUT_DATA_W - BIN_CNT_W - BIN_IDX_W)'(0), out_count, out_index};

endmodule

FILE: hw/rtl/lcch_checker.sv
`timescale 1ns / 1ps
`include "lab_centroid_cell_histogram_core_macros.svh"

module lcch_checker import lcch_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tlast
);

  `LCCH_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
  `LCCH_ASSERT_NEXT(a_pixel_busy, clk, rst, s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_PIXEL), !s_axis_tready)
  `LCCH_ASSERT_NEXT(a_bin_order, clk, rst, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && (m_axis_tdata[3:0] == 4'($past(m_axis_tdata[3:0]) + 4'd1)))
  `LCCH_ASSERT_NOW(a_busy_emit, clk, rst, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)

endmodule

bind lab_centroid_cell_histogram_core lcch_checker u_checker (.*);
